### hw/rtl/bed_pkg.sv
// Package for the backslash escape decoder: payload types, mode codes and helpers.
package bed_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned NibbleW = 4;
  localparam int unsigned ModeW   = 3;

  // Decoder mode codes
  localparam logic [ModeW-1:0] MODE_NORMAL = 3'd0;
  localparam logic [ModeW-1:0] MODE_ESCAPE = 3'd1;
  localparam logic [ModeW-1:0] MODE_HEX_HI = 3'd2;
  localparam logic [ModeW-1:0] MODE_HEX_LO = 3'd3;
  localparam logic [ModeW-1:0] MODE_DROP   = 3'd4;

  // Characters of interest
  localparam logic [CharW-1:0] CHAR_NUL  = 8'h00;
  localparam logic [CharW-1:0] CHAR_BSL  = 8'h5C;
  localparam logic [CharW-1:0] CHAR_R    = 8'h72;
  localparam logic [CharW-1:0] CHAR_N    = 8'h6E;
  localparam logic [CharW-1:0] CHAR_T    = 8'h74;
  localparam logic [CharW-1:0] CHAR_X    = 8'h78;
  localparam logic [CharW-1:0] BYTE_CR   = 8'h0D;
  localparam logic [CharW-1:0] BYTE_LF   = 8'h0A;
  localparam logic [CharW-1:0] BYTE_TAB  = 8'h09;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_TRAIL  = 2'd1,
    ST_BADHEX = 2'd2,
    ST_UNSUP  = 2'd3
  } status_e;

  typedef struct packed {
    logic [CharW-1:0] in_char;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_byte;
    logic             byte_valid;
    status_e          status;
    logic             done_res;
  } out_item_t;

  // One decode step: result request plus the next state
  typedef struct packed {
    logic               emit;
    out_item_t          res;
    logic [ModeW-1:0]   mode_n;
    logic [NibbleW-1:0] nibble_n;
  } step_t;

  typedef struct packed {
    logic               ok;
    logic [NibbleW-1:0] value;
  } hex_t;

  // Decode one hex digit of either case
  function automatic hex_t hex_value(input logic [CharW-1:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = NibbleW'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = NibbleW'(c - 8'h61 + 8'd10);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = NibbleW'(c - 8'h41 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### hw/rtl/bed_stream_if.sv
// Valid/ready stream interface carrying one request payload.
interface bed_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/bed_step.sv
// Combinational decode step: one character against the current mode.
module bed_step (
  input  logic [bed_pkg::ModeW-1:0]   mode_i,
  input  logic [bed_pkg::NibbleW-1:0] nibble_i,
  input  logic [bed_pkg::CharW-1:0]   char_i,
  output bed_pkg::step_t              step_o
);

  bed_pkg::hex_t hex;

  assign hex = bed_pkg::hex_value(char_i);

  always_comb begin
    step_o                = '0;
    step_o.nibble_n       = nibble_i;
    step_o.mode_n         = bed_pkg::MODE_NORMAL;
    step_o.res.status     = bed_pkg::ST_OK;
    case (mode_i)
      bed_pkg::MODE_ESCAPE: begin
        step_o.emit = 1'b1;
        if (char_i == bed_pkg::CHAR_NUL) begin
          step_o.res.status   = bed_pkg::ST_TRAIL;
          step_o.res.done_res = 1'b1;
        end else if (char_i == bed_pkg::CHAR_R) begin
          step_o.res.out_byte   = bed_pkg::BYTE_CR;
          step_o.res.byte_valid = 1'b1;
        end else if (char_i == bed_pkg::CHAR_N) begin
          step_o.res.out_byte   = bed_pkg::BYTE_LF;
          step_o.res.byte_valid = 1'b1;
        end else if (char_i == bed_pkg::CHAR_T) begin
          step_o.res.out_byte   = bed_pkg::BYTE_TAB;
          step_o.res.byte_valid = 1'b1;
        end else if (char_i == bed_pkg::CHAR_BSL) begin
          step_o.res.out_byte   = bed_pkg::CHAR_BSL;
          step_o.res.byte_valid = 1'b1;
        end else if (char_i == bed_pkg::CHAR_X) begin
          step_o.emit   = 1'b0;
          step_o.mode_n = bed_pkg::MODE_HEX_HI;
        end else begin
          step_o.res.status   = bed_pkg::ST_UNSUP;
          step_o.res.done_res = 1'b1;
          step_o.mode_n       = bed_pkg::MODE_DROP;
        end
      end
      bed_pkg::MODE_HEX_HI, bed_pkg::MODE_HEX_LO: begin
        if (char_i == bed_pkg::CHAR_NUL) begin
          step_o.emit         = 1'b1;
          step_o.res.status   = bed_pkg::ST_BADHEX;
          step_o.res.done_res = 1'b1;
        end else if (!hex.ok) begin
          step_o.emit         = 1'b1;
          step_o.res.status   = bed_pkg::ST_BADHEX;
          step_o.res.done_res = 1'b1;
          step_o.mode_n       = bed_pkg::MODE_DROP;
        end else if (mode_i == bed_pkg::MODE_HEX_HI) begin
          step_o.nibble_n = hex.value;
          step_o.mode_n   = bed_pkg::MODE_HEX_LO;
        end else begin
          step_o.emit           = 1'b1;
          step_o.res.out_byte   = {nibble_i, hex.value};
          step_o.res.byte_valid = 1'b1;
        end
      end
      bed_pkg::MODE_DROP: begin
        // drop everything up to the terminating zero
        step_o.mode_n = (char_i == bed_pkg::CHAR_NUL) ? bed_pkg::MODE_NORMAL
                                                       : bed_pkg::MODE_DROP;
      end
      default: begin
        if (char_i == bed_pkg::CHAR_NUL) begin
          step_o.emit         = 1'b1;
          step_o.res.done_res = 1'b1;
        end else if (char_i == bed_pkg::CHAR_BSL) begin
          step_o.mode_n = bed_pkg::MODE_ESCAPE;
        end else begin
          step_o.emit           = 1'b1;
          step_o.res.out_byte   = char_i;
          step_o.res.byte_valid = 1'b1;
        end
      end
    endcase
  end

endmodule

### hw/rtl/backslash_escape_decoder_core.sv
// Top level of the backslash escape decoder: input stage, decode step, result register.
//
//  channel  dir  modport  payload                                   request accepted when
//  in_i     in   sink     in_char[7:0]                              in_i.valid && in_i.ready
//  out_o    out  source   out_byte[7:0] byte_valid status done_res  out_o.valid && out_o.ready
//
//  One character per cycle sustained while out_o does not stall. A request accepted into
//  the input register is decoded by the single step and, when the input stage advances,
//  its result, if it yields one, lands in the result register, which drives out_o.
//  Reset (rst_ni low, asynchronous) empties both stages and returns the mode to normal.
//  The input stage keeps accepting while a result waits in the output register; a stall
//  on out_o backs up into the input stage only when it holds a character that yields a result.
module backslash_escape_decoder_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  bed_stream_if.sink   in_i,
  bed_stream_if.source out_o
);

  // Input stage: one accepted character waiting for its decode step
  logic                        s1_valid_q, s1_valid_d;
  logic [bed_pkg::CharW-1:0]   s1_char_q;

  // Decoder state
  logic [bed_pkg::ModeW-1:0]   mode_q;
  logic [bed_pkg::NibbleW-1:0] nibble_q;

  // Result register
  logic                        out_valid_q, out_valid_d;
  bed_pkg::out_item_t          out_data_q;

  bed_pkg::step_t              step;
  logic                        s1_adv;
  logic                        out_load;
  logic                        in_fire;

  bed_step u_step (
    .mode_i   (mode_q),
    .nibble_i (nibble_q),
    .char_i   (s1_char_q),
    .step_o   (step)
  );

  // Advance the input stage when its character gives no result or the result
  // register is free or draining this cycle.
  assign s1_adv   = s1_valid_q && (!step.emit || !out_valid_q || out_o.ready);
  assign out_load = s1_adv && step.emit;
  assign in_fire  = in_i.valid && in_i.ready;

  assign in_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= bed_pkg::MODE_NORMAL;
      nibble_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      // Commit the step's state only when the character leaves the input stage
      if (s1_adv) begin
        mode_q   <= step.mode_n;
        nibble_q <= step.nibble_n;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= in_i.data.in_char;
    end
    if (out_load) begin
      out_data_q <= step.res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // A stalled input stage holds its character
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_char_q))
    else $error("input stage lost a stalled character");

  // A decoded byte never closes a text
  a_byte_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.byte_valid |-> !out_o.data.done_res &&
    out_o.data.status == bed_pkg::ST_OK)
    else $error("decoded byte flagged as end of text");

  // Every error status ends the text
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status != bed_pkg::ST_OK |-> out_o.data.done_res)
    else $error("error result without end of text");

  // Mode never leaves the defined codes
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= bed_pkg::MODE_DROP)
    else $error("decoder mode out of range");

  // A result is loaded only into a free or draining result register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || out_o.ready)
    else $error("result register overwritten");

endmodule
